// ===== src/ilha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilha_pkg
// Shared types, constants and header helpers of the implicit list heap
// allocator.
// ----------------------------------------------------------------------------
package ilha_pkg;

  localparam int HEAP_BYTES = 65536;
  localparam int HDR_BYTES  = 8;
  localparam int ROWS       = HEAP_BYTES / HDR_BYTES;
  localparam int ROW_W      = $clog2(ROWS);
  localparam int OFF_W      = $clog2(HEAP_BYTES);
  localparam int WOFF_W     = OFF_W + 2;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_INIT  = 2'd2;
  localparam logic [1:0] OP_STATS = 2'd3;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;

  localparam logic CFG_MIN_REQUEST = 1'b0;
  localparam logic CFG_MAX_REQUEST = 1'b1;

  localparam logic [12:0] MIN_REQUEST_RESET = 13'd4;
  localparam logic [15:0] MAX_REQUEST_RESET = 16'd4096;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] request_bytes;
    logic [15:0] owner_task;
    logic [1:0]  fit_strategy;
    logic [15:0] free_pointer;
  } in_beat_t;

  typedef struct packed {
    logic        status;
    logic [15:0] payload_offset;
    logic [15:0] free_total;
    logic [15:0] max_free_block;
    logic [13:0] free_count;
  } out_beat_t;

  typedef struct packed {
    logic              rd_en;
    logic [OFF_W-1:0]  rd_off;
    logic              wr_en;
    logic [WOFF_W-1:0] wr_off;
    logic [63:0]       wr_data;
  } mem_req_t;

  function automatic logic [7:0] hdr_sum(input logic [55:0] b);
    logic [7:0] s;
    s = b[7:0] ^ b[15:8] ^ b[23:16] ^ b[31:24] ^ b[39:32] ^ b[47:40] ^ b[55:48];
    return s;
  endfunction

  function automatic logic [63:0] hdr_pack(input logic [31:0] size, input logic [7:0] st,
                                           input logic [15:0] owner);
    logic [55:0] b;
    b = {owner, st, size};
    return {hdr_sum(b), b};
  endfunction

endpackage

// ===== src/ilha_hdr_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilha_hdr_mem
// Heap byte store in eight byte banks: one unaligned 8-byte header read and
// one unaligned 8-byte header write per cycle, bytes past the end dropped.
// ----------------------------------------------------------------------------
module ilha_hdr_mem (
  input  logic              clk,
  input  ilha_pkg::mem_req_t req,
  output logic [63:0]       rdata
);

  logic [7:0] bank_q [8];
  logic [2:0] rd_rot;

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_rot <= req.rd_off[2:0];
    end
  end

  for (genvar b = 0; b < 8; b++) begin : g_bank
    localparam logic [2:0] BK = 3'(b);
    logic [7:0] mem [ilha_pkg::ROWS];
    logic [ilha_pkg::ROW_W-1:0] rd_row;
    logic [2:0] wk;
    logic [ilha_pkg::WOFF_W-1:0] waddr;
    logic wen;

    always_comb begin
      rd_row = req.rd_off[ilha_pkg::OFF_W-1:3]
             + ilha_pkg::ROW_W'(BK < req.rd_off[2:0]);
      wk     = BK - req.wr_off[2:0];
      waddr  = req.wr_off + ilha_pkg::WOFF_W'(wk);
      wen    = req.wr_en && (waddr[ilha_pkg::WOFF_W-1:ilha_pkg::OFF_W] == '0);
    end

    always_ff @(posedge clk) begin
      if (wen) begin
        mem[waddr[ilha_pkg::OFF_W-1:3]] <= req.wr_data[8*wk +: 8];
      end
      if (req.rd_en) begin
        bank_q[b] <= mem[rd_row];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      rdata[8*k +: 8] = bank_q[3'(rd_rot + 3'(k))];
    end
  end

endmodule

// ===== src/ilha_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilha_seq
// Operation sequencer: walks the header chain one header at a time through
// the shared header port.
// ----------------------------------------------------------------------------
module ilha_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_take,
  input  ilha_pkg::in_beat_t   in_beat,
  input  logic [12:0]          min_request,
  input  logic [15:0]          max_request,
  input  logic [63:0]          rdata,
  input  logic                 res_take,
  output logic                 idle,
  output logic                 res_valid,
  output ilha_pkg::out_beat_t  res,
  output ilha_pkg::mem_req_t   mreq
);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_ISSUE   = 4'd2;
  localparam logic [3:0] S_EVAL    = 4'd3;
  localparam logic [3:0] S_FREE_RD = 4'd4;
  localparam logic [3:0] S_FREE_CK = 4'd5;
  localparam logic [3:0] S_SPLIT   = 4'd6;
  localparam logic [3:0] S_SPLIT2  = 4'd7;
  localparam logic [3:0] S_INITHDR = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  localparam logic [15:0] LAST_OFF = 16'(ilha_pkg::HEAP_BYTES - ilha_pkg::HDR_BYTES);
  localparam logic [31:0] INIT_SIZE = 32'(ilha_pkg::HEAP_BYTES - ilha_pkg::HDR_BYTES);

  logic [3:0]  state;
  logic        boot;
  logic [ilha_pkg::ROW_W-1:0] row;
  logic [1:0]  op;
  logic [1:0]  strat;
  logic [15:0] owner;
  logic [16:0] need;
  logic [15:0] off;
  logic        beyond;
  logic        have_best;
  logic [15:0] best;
  logic [31:0] best_size;
  logic [31:0] best_diff;
  logic [15:0] blk;
  logic [31:0] blk_size;
  logic        have_prev;
  logic [15:0] prev;
  logic [31:0] prev_size;

  logic [31:0] r_size;
  logic [7:0]  r_st;
  logic [15:0] r_owner;
  logic        r_free;
  logic        walk_go;
  logic [33:0] nxt;
  logic [31:0] need32;
  logic [31:0] diff;
  logic        fits;
  logic        take_now;
  logic [31:0] psum;
  logic [31:0] rest;
  logic        do_split;
  logic [16:0] tot_sum;
  logic [15:0] sz_sat;
  logic [15:0] tot_next;
  logic [15:0] big_next;
  logic [13:0] cnt_next;
  logic [16:0] req3;
  logic        free_ok;
  logic        alloc_bad;
  logic        ptr_bad;
  logic        in_reject;

  always_comb begin
    r_size  = rdata[31:0];
    r_st    = rdata[39:32];
    r_owner = rdata[55:40];
    r_free  = (r_st == 8'd0);
    need32  = {15'd0, need};
    fits    = r_size >= need32;
    diff    = r_size - need32;
    take_now = r_free && fits && (strat == ilha_pkg::FIT_FIRST || diff == '0);
    nxt     = 34'(off) + 34'(r_size) + 34'(ilha_pkg::HDR_BYTES);
    psum    = prev_size + r_size + 32'(ilha_pkg::HDR_BYTES);
    rest    = blk_size - need32;
    do_split = {1'b0, rest} >= 33'(ilha_pkg::HDR_BYTES) + 33'(min_request);
    sz_sat  = (r_size[31:16] != '0) ? 16'hFFFF : r_size[15:0];
    tot_sum = {1'b0, res.free_total} + {1'b0, sz_sat};
    tot_next = tot_sum[16] ? 16'hFFFF : tot_sum[15:0];
    big_next = (sz_sat > res.max_free_block) ? sz_sat : res.max_free_block;
    cnt_next = (res.free_count != 14'h3FFF) ? res.free_count + 14'd1 : res.free_count;
    req3    = {1'b0, in_beat.request_bytes} + 17'd3;
    free_ok = (rdata[63:56] == ilha_pkg::hdr_sum(rdata[55:0])) && !r_free;
    alloc_bad = (in_beat.request_bytes < {3'd0, min_request}) ||
                (in_beat.request_bytes > max_request);
    ptr_bad   = (in_beat.free_pointer < 16'(ilha_pkg::HDR_BYTES)) ||
                (in_beat.free_pointer > LAST_OFF);
    in_reject = ((in_beat.op == ilha_pkg::OP_ALLOC) && alloc_bad) ||
                ((in_beat.op == ilha_pkg::OP_FREE) && ptr_bad);
    if (op == ilha_pkg::OP_ALLOC) begin
      walk_go = !beyond && (off <= LAST_OFF);
    end else begin
      walk_go = !beyond && (off < LAST_OFF);
    end
  end

  always_comb begin
    mreq = '0;
    unique case (state)
      S_CLEAR: begin
        mreq.wr_en  = 1'b1;
        mreq.wr_off = {2'b00, row, 3'b000};
      end
      S_INITHDR: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_data = ilha_pkg::hdr_pack(INIT_SIZE, 8'd0, 16'd0);
      end
      S_ISSUE: begin
        mreq.rd_en  = walk_go;
        mreq.rd_off = off;
      end
      S_FREE_RD: begin
        mreq.rd_en  = 1'b1;
        mreq.rd_off = off;
      end
      S_EVAL: begin
        mreq.wr_en   = (op == ilha_pkg::OP_FREE) && r_free && have_prev;
        mreq.wr_off  = {2'b00, prev};
        mreq.wr_data = ilha_pkg::hdr_pack(psum, 8'd0, 16'd0);
      end
      S_FREE_CK: begin
        mreq.wr_en   = free_ok;
        mreq.wr_off  = {2'b00, off};
        mreq.wr_data = ilha_pkg::hdr_pack(r_size, 8'd0, r_owner);
      end
      S_SPLIT: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_off  = {2'b00, blk};
        mreq.wr_data = ilha_pkg::hdr_pack(do_split ? need32 : blk_size, 8'd1, owner);
      end
      S_SPLIT2: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_off  = {2'b00, blk} + 18'(ilha_pkg::HDR_BYTES) + {1'b0, need};
        mreq.wr_data = ilha_pkg::hdr_pack(rest - 32'(ilha_pkg::HDR_BYTES), 8'd0, 16'd0);
      end
      default: begin
        mreq = '0;
      end
    endcase
  end

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      boot  <= 1'b1;
      row   <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          row <= row + 1'b1;
          if (row == ilha_pkg::ROW_W'(ilha_pkg::ROWS - 1)) begin
            state <= S_INITHDR;
          end
        end
        S_INITHDR: begin
          boot  <= 1'b0;
          state <= boot ? S_IDLE : S_DONE;
        end
        S_IDLE: begin
          if (in_take) begin
            op        <= in_beat.op;
            strat     <= in_beat.fit_strategy;
            owner     <= in_beat.owner_task;
            need      <= {req3[16:2], 2'b00};
            off       <= (in_beat.op == ilha_pkg::OP_FREE) ?
                         in_beat.free_pointer - 16'(ilha_pkg::HDR_BYTES) : '0;
            beyond    <= 1'b0;
            have_best <= 1'b0;
            have_prev <= 1'b0;
            res       <= {in_reject, 62'd0};
            unique case (in_beat.op)
              ilha_pkg::OP_ALLOC: begin
                state <= alloc_bad ? S_DONE : S_ISSUE;
              end
              ilha_pkg::OP_FREE: begin
                state <= ptr_bad ? S_DONE : S_FREE_RD;
              end
              ilha_pkg::OP_INIT: begin
                row   <= '0;
                state <= S_CLEAR;
              end
              default: begin
                state <= S_ISSUE;
              end
            endcase
          end
        end
        S_ISSUE: begin
          if (walk_go) begin
            state <= S_EVAL;
          end else if (op == ilha_pkg::OP_ALLOC) begin
            if (have_best) begin
              blk      <= best;
              blk_size <= best_size;
              state    <= S_SPLIT;
            end else begin
              res.status <= 1'b1;
              state      <= S_DONE;
            end
          end else begin
            state <= S_DONE;
          end
        end
        S_EVAL: begin
          off    <= nxt[15:0];
          beyond <= (nxt[33:16] != '0);
          state  <= ((op == ilha_pkg::OP_ALLOC) && take_now) ? S_SPLIT : S_ISSUE;
          unique case (op)
            ilha_pkg::OP_ALLOC: begin
              if (take_now) begin
                blk      <= off;
                blk_size <= r_size;
              end else if (r_free && fits && strat == ilha_pkg::FIT_BEST &&
                           (!have_best || diff < best_diff)) begin
                have_best <= 1'b1;
                best      <= off;
                best_size <= r_size;
                best_diff <= diff;
              end
            end
            ilha_pkg::OP_FREE: begin
              if (r_free) begin
                if (have_prev) begin
                  prev_size <= psum;
                end else begin
                  have_prev <= 1'b1;
                  prev      <= off;
                  prev_size <= r_size;
                end
              end else begin
                have_prev <= 1'b0;
              end
            end
            default: begin
              if (r_free) begin
                res <= {res.status, res.payload_offset, tot_next, big_next, cnt_next};
              end
            end
          endcase
        end
        S_FREE_RD: begin
          state <= S_FREE_CK;
        end
        S_FREE_CK: begin
          if (free_ok) begin
            off    <= '0;
            beyond <= 1'b0;
            state  <= S_ISSUE;
          end else begin
            res.status <= 1'b1;
            state      <= S_DONE;
          end
        end
        S_SPLIT: begin
          res.payload_offset <= blk + 16'(ilha_pkg::HDR_BYTES);
          state <= do_split ? S_SPLIT2 : S_DONE;
        end
        S_SPLIT2: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/implicit_list_heap_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// implicit_list_heap_allocator_core
// Implicit free list heap allocator with first, best and exact fit, free with
// merging of free runs, reinitialise and statistics over a 64 KiB byte heap.
// ----------------------------------------------------------------------------
// walk: each header visited is read in S_ISSUE and checked in S_EVAL; a free reads
// its header first and then walks the whole chain to merge
// reinitialise clears one heap row of eight bytes a cycle, then writes one free block header
// throughput: one operation at a time, bound by the single header port
// reset: a clearing pass, then the heap holds one free block
module implicit_list_heap_allocator_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ilha_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ilha_pkg::out_beat_t  out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_wdata
);

  logic [12:0] min_request;
  logic [15:0] max_request;
  logic        idle;
  logic        res_valid;
  logic        res_take;
  logic        in_take;
  logic [63:0] rdata;
  ilha_pkg::out_beat_t res;
  ilha_pkg::mem_req_t  mreq;

  assign in_stall = !idle;
  assign in_take  = in_valid && idle;
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_request <= ilha_pkg::MIN_REQUEST_RESET;
      max_request <= ilha_pkg::MAX_REQUEST_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ilha_pkg::CFG_MIN_REQUEST: min_request <= cfg_wdata[12:0];
        ilha_pkg::CFG_MAX_REQUEST: max_request <= cfg_wdata;
        default: min_request <= min_request;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= res;
    end
  end

  ilha_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_take     (in_take),
    .in_beat     (in_data),
    .min_request (min_request),
    .max_request (max_request),
    .rdata       (rdata),
    .res_take    (res_take),
    .idle        (idle),
    .res_valid   (res_valid),
    .res         (res),
    .mreq        (mreq)
  );

  ilha_hdr_mem u_mem (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  a_boot_busy: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input taken during clearing pass");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("sequencer ready right after taking a beat");

  a_no_take_with_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> in_stall)
    else $error("input accepted while a result is pending");

endmodule
